// ===== src/sdc_pkg.sv =====
// ----------------------------------------------------------------------------
// sdc_pkg
// Shared constants and types for the swinging door compressor: default
// widths, register indexes and reset values, and the multiplier control group.
// ----------------------------------------------------------------------------
package sdc_pkg;

	// default geometry
	localparam int COORD_WIDTH_DEF = 32;
	localparam int COUNT_WIDTH_DEF = 16;

	// width of exact cross products, determinants and quotients
	localparam int WIDE_W = 128;

	// configuration registers
	localparam int DEV_W      = 31;
	localparam int TLIM_W     = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 31;

	localparam logic [CFG_IDX_W-1:0] REG_DEVIATION  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_LIMIT = 2'd1;

	localparam logic [DEV_W-1:0]  DEV_RESET  = 31'd65536;
	localparam logic [TLIM_W-1:0] TLIM_RESET = 16'hFFFF;

	// control of the shared multiply-accumulate unit
	typedef struct packed {
		logic start;  // latch operands and begin a product
		logic clear;  // accumulator starts from zero
		logic neg;    // subtract the product instead of adding it
	} mac_ctl_t;

endpackage

// ===== src/sdc_mac.sv =====
// ----------------------------------------------------------------------------
// sdc_mac
// Bit-serial signed multiply-accumulate. One multiplier bit per cycle,
// wide multiplicand, accumulator kept modulo 2^WIDE_W.
// ----------------------------------------------------------------------------
module sdc_mac #(
	parameter int MUL_WIDTH = sdc_pkg::COORD_WIDTH_DEF + 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  sdc_pkg::mac_ctl_t                   ctl,
	input  logic signed [sdc_pkg::WIDE_W-1:0]   mcand,
	input  logic signed [MUL_WIDTH-1:0]         mplier,
	output logic        [sdc_pkg::WIDE_W-1:0]   acc,
	output logic                                done
);
	import sdc_pkg::*;

	localparam int CNTW = $clog2(MUL_WIDTH);

	logic [WIDE_W-1:0]    acc_q;
	logic [WIDE_W-1:0]    mc_q;
	logic [MUL_WIDTH-1:0] mp_q;
	logic [CNTW-1:0]      cnt_q;
	logic                 busy_q;
	logic                 neg_q;
	logic                 done_q;
	logic                 last;
	logic                 sub;

	// the top multiplier bit carries negative weight
	assign last = (cnt_q == CNTW'(MUL_WIDTH - 1));
	assign sub  = last ^ neg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				mc_q   <= mcand;
				mp_q   <= mplier;
				neg_q  <= ctl.neg;
				cnt_q  <= '0;
				busy_q <= 1'b1;
				if (ctl.clear) begin
					acc_q <= '0;
				end
			end else if (busy_q) begin
				if (mp_q[0]) begin
					acc_q <= acc_q + (mc_q ^ {WIDE_W{sub}}) + WIDE_W'(sub);
				end
				mc_q  <= {mc_q[WIDE_W-2:0], 1'b0};
				mp_q  <= {1'b0, mp_q[MUL_WIDTH-1:1]};
				cnt_q <= cnt_q + CNTW'(1);
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign acc  = acc_q;
	assign done = done_q;

endmodule

// ===== src/sdc_div.sv =====
// ----------------------------------------------------------------------------
// sdc_div
// Restoring signed divider, one quotient bit per cycle, truncating toward
// zero. A final step restores the sign of the quotient.
// ----------------------------------------------------------------------------
module sdc_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [sdc_pkg::WIDE_W-1:0]    num,
	input  logic [sdc_pkg::WIDE_W-1:0]    den,
	output logic [sdc_pkg::WIDE_W-1:0]    quot,
	output logic                          done
);
	import sdc_pkg::*;

	localparam int CNTW = $clog2(WIDE_W);

	logic [WIDE_W-1:0] rem_q;
	logic [WIDE_W-1:0] qn_q;
	logic [WIDE_W-1:0] ud_q;
	logic [WIDE_W-1:0] quot_q;
	logic [CNTW-1:0]   cnt_q;
	logic              busy_q;
	logic              fin_q;
	logic              done_q;
	logic              neg_q;
	logic [WIDE_W-1:0] shifted;
	logic              ge;

	// remainder stays below the divisor, so its top bit is always clear
	assign shifted = {rem_q[WIDE_W-2:0], qn_q[WIDE_W-1]};
	assign ge      = (shifted >= ud_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				qn_q   <= num[WIDE_W-1] ? (~num + WIDE_W'(1)) : num;
				ud_q   <= den[WIDE_W-1] ? (~den + WIDE_W'(1)) : den;
				neg_q  <= num[WIDE_W-1] ^ den[WIDE_W-1];
				rem_q  <= '0;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= ge ? (shifted - ud_q) : shifted;
				qn_q  <= {qn_q[WIDE_W-2:0], ge};
				cnt_q <= cnt_q + CNTW'(1);
				if (cnt_q == CNTW'(WIDE_W - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				quot_q <= neg_q ? (~qn_q + WIDE_W'(1)) : qn_q;
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	assign quot = quot_q;
	assign done = done_q;

endmodule

// ===== src/swinging_door_compressor_unit.sv =====
// ----------------------------------------------------------------------------
// swinging_door_compressor_unit
// Swinging door trend compressor: one sample in, one stored-point report out.
// Each sample uses products on the bit-serial MAC and quotients on the divider.
// A sample inside the door costs six products; each swung line adds seven
// products and two divisions; a store adds two products.
// One sample at a time; the next is taken once the report has been taken.
// Reset (async, active low) and a write to either config register clear the door state.
// ----------------------------------------------------------------------------
module swinging_door_compressor_unit #(
	parameter int COORD_WIDTH = sdc_pkg::COORD_WIDTH_DEF,
	parameter int COUNT_WIDTH = sdc_pkg::COUNT_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [sdc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [sdc_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [COORD_WIDTH-1:0]        sample_x,
	input  logic signed [COORD_WIDTH-1:0]        sample_y,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 stored_changed,
	output logic signed [COORD_WIDTH-1:0]        stored_x,
	output logic signed [COORD_WIDTH-1:0]        stored_y
);
	import sdc_pkg::*;

	localparam int DW = COORD_WIDTH + 1;
	localparam int AW = WIDE_W;
	localparam int EW = ((COORD_WIDTH > DEV_W) ? COORD_WIDTH : DEV_W) + 2;
	localparam int TW = (COUNT_WIDTH > TLIM_W) ? COUNT_WIDTH : TLIM_W;
	localparam logic signed [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_STORE = 9'b000000010,
		S_SETL  = 9'b000000100,
		S_MGO   = 9'b000001000,
		S_MWAIT = 9'b000010000,
		S_DGO   = 9'b000100000,
		S_DWAIT = 9'b001000000,
		S_TAIL  = 9'b010000000,
		S_OUT   = 9'b100000000
	} state_t;

	typedef enum logic [3:0] {
		U_CLS0A, U_CLS0B, U_CLS1A, U_CLS1B, U_CLS2A, U_CLS2B,
		U_LC, U_DETA, U_DETB, U_DXA, U_DXB, U_DYA, U_DYB, U_SCU, U_SCL
	} uop_t;

	function automatic logic signed [COORD_WIDTH-1:0] sat_wide(
		input logic signed [AW-1:0] v
	);
		logic signed [COORD_WIDTH-1:0] r;
		if (v > AW'(CMAX)) begin
			r = CMAX;
		end else if (v < AW'(CMIN)) begin
			r = CMIN;
		end else begin
			r = v[COORD_WIDTH-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [COORD_WIDTH-1:0] sat_ext(
		input logic signed [EW-1:0] v
	);
		logic signed [COORD_WIDTH-1:0] r;
		if (v > EW'(CMAX)) begin
			r = CMAX;
		end else if (v < EW'(CMIN)) begin
			r = CMIN;
		end else begin
			r = v[COORD_WIDTH-1:0];
		end
		return r;
	endfunction

	state_t state_q;
	uop_t   uop_q;

	logic                           ready_q;
	logic [COUNT_WIDTH-1:0]         cnt_q;
	logic [DEV_W-1:0]               dev_q;
	logic [TLIM_W-1:0]              tl_q;
	logic signed [COORD_WIDTH-1:0]  smp_x_q, smp_y_q;
	logic signed [COORD_WIDTH-1:0]  st_x_q, st_y_q;
	logic signed [COORD_WIDTH-1:0]  pv_x_q, pv_y_q;
	logic signed [COORD_WIDTH-1:0]  anc_x_q, lo_y_q, up_y_q;
	logic signed [COORD_WIDTH-1:0]  piv_x_q, piv_y_q, newx_q;
	logic signed [DW-1:0]           la_q, lb_q, ua_q, ub_q;
	logic signed [AW-1:0]           lc_q, uc_q, det_q, numx_q;
	logic                           changed_q;
	logic                           slu_neg_q, slu_zero_q, sl_neg_q, sl_zero_q;
	logic                           double_q, upper_q, tail_q, store_prev_q, div_y_q;

	// shared units
	mac_ctl_t                mac_ctl;
	logic signed [AW-1:0]    mac_mcand;
	logic signed [DW-1:0]    mac_mplier;
	logic [AW-1:0]           mac_acc;
	logic                    mac_done;
	logic signed [AW-1:0]    acc_s;
	logic                    acc_neg, acc_zero;
	logic [AW-1:0]           div_num;
	logic [AW-1:0]           div_quot;
	logic                    div_done;
	logic signed [AW-1:0]    quot_s;
	logic signed [AW-1:0]    x_sum;
	logic signed [COORD_WIDTH-1:0] x_sat, y_sat;

	sdc_mac #(
		.MUL_WIDTH (DW)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.mcand  (mac_mcand),
		.mplier (mac_mplier),
		.acc    (mac_acc),
		.done   (mac_done)
	);

	sdc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_DGO),
		.num    (div_num),
		.den    (det_q),
		.quot   (div_quot),
		.done   (div_done)
	);

	assign acc_s    = mac_acc;
	assign acc_neg  = acc_s[AW-1];
	assign acc_zero = (mac_acc == '0);
	assign div_num  = div_y_q ? mac_acc : numx_q;
	assign quot_s   = div_quot;
	assign x_sum    = quot_s + AW'(anc_x_q);
	assign x_sat    = sat_wide(x_sum);
	assign y_sat    = sat_wide(quot_s);

	// store point: from the held sample or from the previous sample
	logic signed [COORD_WIDTH-1:0] st_sx, st_sy, lo_new, up_new;
	logic signed [EW-1:0]          sy_e, dev_e;
	logic signed [DW-1:0]          sa_lo, sa_up, sb;

	assign st_sx  = store_prev_q ? pv_x_q : smp_x_q;
	assign st_sy  = store_prev_q ? pv_y_q : smp_y_q;
	assign sy_e   = EW'(st_sy);
	assign dev_e  = EW'(dev_q);
	assign lo_new = sat_ext(sy_e - dev_e);
	assign up_new = sat_ext(sy_e + dev_e);
	assign sa_lo  = DW'(lo_new) - DW'(smp_y_q);
	assign sa_up  = DW'(up_new) - DW'(smp_y_q);
	assign sb     = DW'(smp_x_q) - DW'(st_sx);

	// moved line through its anchor and the sample
	logic signed [COORD_WIDTH-1:0] ln_ay;
	logic signed [DW-1:0]          ln_a, ln_b;

	assign ln_ay = upper_q ? up_y_q : lo_y_q;
	assign ln_a  = DW'(ln_ay) - DW'(smp_y_q);
	assign ln_b  = DW'(smp_x_q) - DW'(anc_x_q);

	// orientation tests: lower-upper, lower-pivot, upper-pivot
	logic [1:0]                    cls_k;
	logic signed [COORD_WIDTH-1:0] c_ay, c_bx, c_by;
	logic signed [DW-1:0]          d_bx, d_by, d_px, d_py;

	always_comb begin
		unique case (uop_q)
			U_CLS0A, U_CLS0B: cls_k = 2'd0;
			U_CLS1A, U_CLS1B: cls_k = 2'd1;
			default:          cls_k = 2'd2;
		endcase
	end

	assign c_ay = (cls_k == 2'd2) ? up_y_q : lo_y_q;
	assign c_bx = (cls_k == 2'd0) ? anc_x_q : piv_x_q;
	assign c_by = (cls_k == 2'd0) ? up_y_q : piv_y_q;
	assign d_bx = DW'(c_bx) - DW'(anc_x_q);
	assign d_by = DW'(c_by) - DW'(c_ay);
	assign d_px = DW'(smp_x_q) - DW'(anc_x_q);
	assign d_py = DW'(smp_y_q) - DW'(c_ay);

	// operand selection for the MAC
	always_comb begin
		mac_ctl.start = (state_q == S_MGO);
		mac_ctl.clear = 1'b1;
		mac_ctl.neg   = 1'b0;
		mac_mcand     = AW'(d_bx);
		mac_mplier    = d_py;
		unique case (uop_q)
			U_CLS0A, U_CLS1A, U_CLS2A: begin
				mac_mcand  = AW'(d_bx);
				mac_mplier = d_py;
			end
			U_CLS0B, U_CLS1B, U_CLS2B: begin
				mac_ctl.clear = 1'b0;
				mac_ctl.neg   = 1'b1;
				mac_mcand     = AW'(d_by);
				mac_mplier    = d_px;
			end
			U_LC: begin
				mac_mcand  = AW'(ln_ay);
				mac_mplier = upper_q ? ub_q : lb_q;
			end
			U_DETA: begin
				mac_mcand  = AW'(la_q);
				mac_mplier = ub_q;
			end
			U_DETB: begin
				mac_ctl.clear = 1'b0;
				mac_ctl.neg   = 1'b1;
				mac_mcand     = AW'(lb_q);
				mac_mplier    = ua_q;
			end
			U_DXA: begin
				mac_mcand  = lc_q;
				mac_mplier = ub_q;
			end
			U_DXB: begin
				mac_ctl.clear = 1'b0;
				mac_ctl.neg   = 1'b1;
				mac_mcand     = uc_q;
				mac_mplier    = lb_q;
			end
			U_DYA: begin
				mac_mcand  = uc_q;
				mac_mplier = la_q;
			end
			U_DYB: begin
				mac_ctl.clear = 1'b0;
				mac_ctl.neg   = 1'b1;
				mac_mcand     = lc_q;
				mac_mplier    = ua_q;
			end
			U_SCU: begin
				mac_mcand  = AW'(up_y_q);
				mac_mplier = ub_q;
			end
			U_SCL: begin
				mac_mcand  = AW'(lo_y_q);
				mac_mplier = lb_q;
			end
			default: begin
				mac_ctl.start = 1'b0;
			end
		endcase
	end

	// door position of the sample
	logic sl_pos, su_pos, su_neg, in_door;

	assign sl_pos  = !sl_neg_q && !sl_zero_q;
	assign su_neg  = acc_neg;
	assign su_pos  = !acc_neg && !acc_zero;
	assign in_door = (slu_zero_q && sl_zero_q && acc_zero) ||
	                 (slu_neg_q && sl_pos && su_neg);

	// sequencer and door state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			uop_q   <= U_CLS0A;
			ready_q <= 1'b0;
			cnt_q   <= '0;
			dev_q   <= DEV_RESET;
			tl_q    <= TLIM_RESET;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						smp_x_q   <= sample_x;
						smp_y_q   <= sample_y;
						changed_q <= 1'b0;
						if (!ready_q) begin
							store_prev_q <= 1'b0;
							tail_q       <= 1'b0;
							state_q      <= S_STORE;
						end else begin
							uop_q   <= U_CLS0A;
							state_q <= S_MGO;
						end
					end
				end
				S_STORE: begin
					anc_x_q   <= st_sx;
					lo_y_q    <= lo_new;
					up_y_q    <= up_new;
					st_x_q    <= st_sx;
					st_y_q    <= st_sy;
					pv_x_q    <= st_sx;
					pv_y_q    <= st_sy;
					piv_x_q   <= smp_x_q;
					piv_y_q   <= smp_y_q;
					la_q      <= sa_lo;
					ua_q      <= sa_up;
					lb_q      <= sb;
					ub_q      <= sb;
					ready_q   <= 1'b1;
					changed_q <= 1'b1;
					cnt_q     <= '0;
					uop_q     <= U_SCU;
					state_q   <= S_MGO;
				end
				S_SETL: begin
					if (upper_q) begin
						ua_q <= ln_a;
						ub_q <= ln_b;
					end else begin
						la_q <= ln_a;
						lb_q <= ln_b;
					end
					uop_q   <= U_LC;
					state_q <= S_MGO;
				end
				S_MGO: begin
					state_q <= S_MWAIT;
				end
				S_MWAIT: begin
					if (mac_done) begin
						unique case (uop_q)
							U_CLS0A: begin
								uop_q   <= U_CLS0B;
								state_q <= S_MGO;
							end
							U_CLS0B: begin
								slu_neg_q  <= acc_neg;
								slu_zero_q <= acc_zero;
								uop_q      <= U_CLS1A;
								state_q    <= S_MGO;
							end
							U_CLS1A: begin
								uop_q   <= U_CLS1B;
								state_q <= S_MGO;
							end
							U_CLS1B: begin
								sl_neg_q  <= acc_neg;
								sl_zero_q <= acc_zero;
								uop_q     <= U_CLS2A;
								state_q   <= S_MGO;
							end
							U_CLS2A: begin
								uop_q   <= U_CLS2B;
								state_q <= S_MGO;
							end
							U_CLS2B: begin
								// swing lower first on a double swing
								if (in_door) begin
									state_q <= S_TAIL;
								end else if (sl_neg_q && su_pos) begin
									double_q <= 1'b1;
									upper_q  <= 1'b0;
									state_q  <= S_SETL;
								end else if (sl_neg_q) begin
									double_q <= 1'b0;
									upper_q  <= 1'b0;
									state_q  <= S_SETL;
								end else if (su_pos) begin
									double_q <= 1'b0;
									upper_q  <= 1'b1;
									state_q  <= S_SETL;
								end else begin
									state_q <= S_TAIL;
								end
							end
							U_LC: begin
								if (upper_q) begin
									uc_q <= acc_s;
								end else begin
									lc_q <= acc_s;
								end
								uop_q   <= U_DETA;
								state_q <= S_MGO;
							end
							U_DETA: begin
								uop_q   <= U_DETB;
								state_q <= S_MGO;
							end
							U_DETB: begin
								// parallel lines: fall back to the previous sample
								if (acc_zero) begin
									store_prev_q <= 1'b1;
									tail_q       <= 1'b1;
									state_q      <= S_STORE;
								end else begin
									det_q   <= acc_s;
									uop_q   <= U_DXA;
									state_q <= S_MGO;
								end
							end
							U_DXA: begin
								uop_q   <= U_DXB;
								state_q <= S_MGO;
							end
							U_DXB: begin
								numx_q  <= acc_s;
								uop_q   <= U_DYA;
								state_q <= S_MGO;
							end
							U_DYA: begin
								uop_q   <= U_DYB;
								state_q <= S_MGO;
							end
							U_DYB: begin
								div_y_q <= 1'b0;
								state_q <= S_DGO;
							end
							U_SCU: begin
								uc_q    <= acc_s;
								uop_q   <= U_SCL;
								state_q <= S_MGO;
							end
							U_SCL: begin
								lc_q    <= acc_s;
								state_q <= tail_q ? S_TAIL : S_OUT;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_DGO: begin
					state_q <= S_DWAIT;
				end
				S_DWAIT: begin
					if (div_done) begin
						if (!div_y_q) begin
							newx_q  <= x_sat;
							div_y_q <= 1'b1;
							state_q <= S_DGO;
						end else if (newx_q > piv_x_q) begin
							piv_x_q <= newx_q;
							piv_y_q <= y_sat;
							if (double_q && !upper_q) begin
								upper_q <= 1'b1;
								state_q <= S_SETL;
							end else begin
								state_q <= S_TAIL;
							end
						end else begin
							// pivot did not advance
							store_prev_q <= 1'b1;
							tail_q       <= 1'b1;
							state_q      <= S_STORE;
						end
					end
				end
				S_TAIL: begin
					pv_x_q <= smp_x_q;
					pv_y_q <= smp_y_q;
					if (cnt_q != '1) begin
						cnt_q <= cnt_q + COUNT_WIDTH'(1);
					end
					// compare uses the count before it steps
					if (TW'(cnt_q) >= TW'(tl_q)) begin
						store_prev_q <= 1'b0;
						tail_q       <= 1'b0;
						state_q      <= S_STORE;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// a write to either config register clears the door
			if (cfg_we) begin
				if (cfg_index == REG_DEVIATION) begin
					dev_q   <= cfg_data[DEV_W-1:0];
					ready_q <= 1'b0;
					cnt_q   <= '0;
				end else if (cfg_index == REG_TIME_LIMIT) begin
					tl_q    <= cfg_data[TLIM_W-1:0];
					ready_q <= 1'b0;
					cnt_q   <= '0;
				end
			end
		end
	end

	assign in_ready       = (state_q == S_IDLE);
	assign out_valid      = (state_q == S_OUT);
	assign stored_changed = changed_q;
	assign stored_x       = st_x_q;
	assign stored_y       = st_y_q;

endmodule
